FILE: design/tmn_pkg.sv
// Shared types, codes and constants for the token mutex node.
// Used by every module of the block; depends on nothing.
package tmn_pkg;

  localparam int SLOTS         = 8;
  localparam int NODE_BITS     = 3;
  localparam int BYTE_BITS     = 8;
  localparam int LEN_BITS      = 4;
  localparam int MAX_NODES_DEF = 8;
  localparam int SEQ_BITS_DEF  = 8;

  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [1:0] CFG_START_TOK  = 2'd2;

  typedef enum logic [1:0] {
    ACT_PEER  = 2'd0,
    ACT_WANT  = 2'd1,
    ACT_TOKEN = 2'd2,
    ACT_EXIT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MSG_NONE  = 2'd0,
    MSG_BCAST = 2'd1,
    MSG_TOKEN = 2'd2,
    MSG_ENTER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_RELEASED  = 2'd0,
    PH_REQUESTED = 2'd1,
    PH_GRANTED   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SCAN = 2'd2,
    ST_POP  = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_MAX  = 2'd1,
    ALU_INC  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] me;
    logic [LEN_BITS-1:0]  n;
    logic                 hold_load;
    logic                 hold_val;
  } cfg_view_t;

  typedef struct packed {
    kind_t                          kind;
    logic [NODE_BITS-1:0]           dest;
    logic [BYTE_BITS-1:0]           own_seq;
    logic [SLOTS*BYTE_BITS-1:0]     served;
    logic [SLOTS*NODE_BITS-1:0]     queue;
    logic [LEN_BITS-1:0]            qlen;
    phase_t                         phase;
  } res_t;

endpackage

FILE: design/tmn_alu.sv
// Shared sequence-number unit: pass-through, saturating max, saturating increment and
// the "request is next to serve" compare. Depends on tmn_pkg.
module tmn_alu import tmn_pkg::*; #(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  alu_op_t              op,
  input  logic [BYTE_BITS-1:0] seq,
  input  logic [SEQ_BITS-1:0]  req,
  input  logic [SEQ_BITS-1:0]  served,
  output logic [SEQ_BITS-1:0]  res,
  output logic                 match
);

  localparam logic [SEQ_BITS-1:0]  SeqMax  = {SEQ_BITS{1'b1}};
  localparam logic [BYTE_BITS-1:0] SeqMaxB = BYTE_BITS'((1 << SEQ_BITS) - 1);

  logic [SEQ_BITS-1:0] seq_sat;

  assign seq_sat = (seq > SeqMaxB) ? SeqMax : seq[SEQ_BITS-1:0];

  always_comb begin
    case (op)
      ALU_MAX:  res = (seq_sat > req) ? seq_sat : req;
      ALU_INC:  res = (req == SeqMax) ? req : req + 1'b1;
      ALU_PASS: res = req;
      default:  res = req;
    endcase
  end

  assign match = ({1'b0, res} == ({1'b0, served} + 1'b1));

endmodule

FILE: design/tmn_core.sv
// Sequencer and node state: request/served tables, wait queue, phase and
// token ownership. Exit scans the nodes one per cycle through tmn_alu.
// Depends on tmn_pkg and tmn_alu.
module tmn_core import tmn_pkg::*; #(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_view_t                  cfg,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic [NODE_BITS-1:0]       in_source_node,
  input  logic [BYTE_BITS-1:0]       in_request_seq,
  input  logic [SLOTS*BYTE_BITS-1:0] in_token_served,
  input  logic [SLOTS*NODE_BITS-1:0] in_token_queue,
  input  logic [LEN_BITS-1:0]        in_token_queue_len,
  output logic                       done,
  output res_t                       res
);

  localparam logic [SEQ_BITS-1:0]  SeqMax  = {SEQ_BITS{1'b1}};
  localparam logic [BYTE_BITS-1:0] SeqMaxB = BYTE_BITS'((1 << SEQ_BITS) - 1);
  localparam logic [LEN_BITS-1:0]  SlotsL  = LEN_BITS'(SLOTS);

  state_t                       state_r, state_nxt;
  action_t                      act_r, act_nxt;
  logic [NODE_BITS-1:0]         src_r, src_nxt;
  logic [BYTE_BITS-1:0]         seq_r, seq_nxt;
  logic [SLOTS*BYTE_BITS-1:0]   tsrv_r, tsrv_nxt;
  logic [SLOTS*NODE_BITS-1:0]   tq_r, tq_nxt;
  logic [LEN_BITS-1:0]          tlen_r, tlen_nxt;
  logic [LEN_BITS-1:0]          cnt_r, cnt_nxt;
  logic [SEQ_BITS-1:0]          req_r [SLOTS];
  logic [SEQ_BITS-1:0]          req_nxt [SLOTS];
  logic [SEQ_BITS-1:0]          served_r [SLOTS];
  logic [SEQ_BITS-1:0]          served_nxt [SLOTS];
  logic [NODE_BITS-1:0]         queue_r [SLOTS];
  logic [NODE_BITS-1:0]         queue_nxt [SLOTS];
  logic [LEN_BITS-1:0]          qlen_r, qlen_nxt;
  phase_t                       phase_r, phase_nxt;
  logic                         holding_r, holding_nxt;
  res_t                         res_r, res_nxt;
  logic                         done_r, done_nxt;

  logic [NODE_BITS-1:0]         idx;
  alu_op_t                      alu_op;
  logic [SEQ_BITS-1:0]          alu_res;
  logic                         alu_match;
  logic                         queued;
  logic [SLOTS*BYTE_BITS-1:0]   served_pack;
  logic [SLOTS*NODE_BITS-1:0]   queue_pack;
  logic [SLOTS*NODE_BITS-1:0]   shift_pack;
  logic [BYTE_BITS-1:0]         tbyte;
  logic                         finish;
  res_t                         res_v;

  always_comb begin
    case (state_r)
      ST_EXEC: idx = (act_r == ACT_PEER) ? src_r : cfg.me;
      ST_SCAN: idx = cnt_r[NODE_BITS-1:0];
      default: idx = cfg.me;
    endcase
    case (act_r)
      ACT_PEER: alu_op = (state_r == ST_EXEC) ? ALU_MAX : ALU_PASS;
      ACT_WANT: alu_op = (state_r == ST_EXEC) ? ALU_INC : ALU_PASS;
      default:  alu_op = ALU_PASS;
    endcase
  end

  tmn_alu #(.SEQ_BITS(SEQ_BITS)) u_alu (
    .op     (alu_op),
    .seq    (seq_r),
    .req    (req_r[idx]),
    .served (served_r[idx]),
    .res    (alu_res),
    .match  (alu_match)
  );

  always_comb begin
    queued = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if ((LEN_BITS'(k) < qlen_r) && (queue_r[k] == idx)) queued = 1'b1;
      served_pack[k*BYTE_BITS +: BYTE_BITS] = BYTE_BITS'(served_r[k]);
      queue_pack[k*NODE_BITS +: NODE_BITS]  = queue_r[k];
    end
    for (int k = 0; k < SLOTS - 1; k++) begin
      shift_pack[k*NODE_BITS +: NODE_BITS] = queue_r[k+1];
    end
    shift_pack[(SLOTS-1)*NODE_BITS +: NODE_BITS] = '0;
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    src_nxt     = src_r;
    seq_nxt     = seq_r;
    tsrv_nxt    = tsrv_r;
    tq_nxt      = tq_r;
    tlen_nxt    = tlen_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    served_nxt  = served_r;
    queue_nxt   = queue_r;
    qlen_nxt    = qlen_r;
    phase_nxt   = phase_r;
    holding_nxt = holding_r;
    res_nxt     = res_r;
    done_nxt    = 1'b0;
    finish      = 1'b0;
    tbyte       = '0;
    res_v       = '{kind: MSG_NONE, phase: PH_RELEASED, default: '0};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = action_t'(in_action);
          src_nxt   = in_source_node;
          seq_nxt   = in_request_seq;
          tsrv_nxt  = in_token_served;
          tq_nxt    = in_token_queue;
          tlen_nxt  = in_token_queue_len;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        finish = 1'b1;
        case (act_r)
          ACT_PEER: begin
            if ((LEN_BITS'(src_r) < cfg.n) && (src_r != cfg.me)) begin
              req_nxt[src_r] = alu_res;
              if ((phase_r == PH_RELEASED) && holding_r && alu_match) begin
                res_v.kind   = MSG_TOKEN;
                res_v.dest   = src_r;
                res_v.served = served_pack;
                res_v.queue  = queue_pack;
                res_v.qlen   = qlen_r;
                holding_nxt  = 1'b0;
              end
            end
          end
          ACT_WANT: begin
            if (phase_r == PH_RELEASED) begin
              if (holding_r) begin
                phase_nxt  = PH_GRANTED;
                res_v.kind = MSG_ENTER;
              end else begin
                req_nxt[cfg.me] = alu_res;
                phase_nxt       = PH_REQUESTED;
                res_v.kind      = MSG_BCAST;
                res_v.own_seq   = BYTE_BITS'(alu_res);
              end
            end
          end
          ACT_TOKEN: begin
            if ((phase_r == PH_REQUESTED) && !holding_r) begin
              for (int i = 0; i < SLOTS; i++) begin
                tbyte         = tsrv_r[i*BYTE_BITS +: BYTE_BITS];
                served_nxt[i] = (tbyte > SeqMaxB) ? SeqMax : tbyte[SEQ_BITS-1:0];
                queue_nxt[i]  = tq_r[i*NODE_BITS +: NODE_BITS];
              end
              qlen_nxt    = (tlen_r > SlotsL) ? SlotsL : tlen_r;
              holding_nxt = 1'b1;
              phase_nxt   = PH_GRANTED;
              res_v.kind  = MSG_ENTER;
            end
          end
          ACT_EXIT: begin
            if (phase_r == PH_GRANTED) begin
              served_nxt[cfg.me] = req_r[cfg.me];
              cnt_nxt            = '0;
              state_nxt          = ST_SCAN;
              finish             = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (cnt_r < cfg.n) begin
          if ((idx != cfg.me) && alu_match && !queued && (qlen_r < SlotsL)) begin
            queue_nxt[qlen_r[NODE_BITS-1:0]] = idx;
            qlen_nxt                         = qlen_r + 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        finish = 1'b1;
        if (qlen_r != '0) begin
          for (int k = 0; k < SLOTS - 1; k++) begin
            queue_nxt[k] = queue_r[k+1];
          end
          queue_nxt[SLOTS-1] = '0;
          qlen_nxt           = qlen_r - 1'b1;
          res_v.kind         = MSG_TOKEN;
          res_v.dest         = queue_r[0];
          res_v.served       = served_pack;
          res_v.queue        = shift_pack;
          res_v.qlen         = qlen_r - 1'b1;
          holding_nxt        = 1'b0;
        end
        phase_nxt = PH_RELEASED;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (finish) begin
      res_v.phase = phase_nxt;
      res_nxt     = res_v;
      done_nxt    = 1'b1;
      state_nxt   = ST_IDLE;
    end

    if (cfg.hold_load) holding_nxt = cfg.hold_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= PH_RELEASED;
      holding_r <= 1'b0;
      qlen_r    <= '0;
      cnt_r     <= '0;
      done_r    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        req_r[i]    <= '0;
        served_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      holding_r <= holding_nxt;
      qlen_r    <= qlen_nxt;
      cnt_r     <= cnt_nxt;
      done_r    <= done_nxt;
      req_r     <= req_nxt;
      served_r  <= served_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    src_r   <= src_nxt;
    seq_r   <= seq_nxt;
    tsrv_r  <= tsrv_nxt;
    tq_r    <= tq_nxt;
    tlen_r  <= tlen_nxt;
    queue_r <= queue_nxt;
    res_r   <= res_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign done = done_r;
  assign res  = res_r;

  a_qlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qlen_r <= SlotsL)
    else $error("wait queue length out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == ST_IDLE)
    else $error("result strobe while sequencer busy");

  a_token_gone: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && res_r.kind == MSG_TOKEN |-> !holding_r)
    else $error("token sent but still held");

  a_enter_granted: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && res_r.kind == MSG_ENTER |-> phase_r == PH_GRANTED && holding_r)
    else $error("entry grant without token");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= SlotsL)
    else $error("scan counter overran");

endmodule

FILE: design/token_mutex_node.sv
// Top level of the token mutex node: configuration registers, port naming
// and the result strobe. Depends on tmn_pkg and tmn_core.
//
// Usage:
//   Events enter on the in_ ports; one is taken at a clock edge where start
//   is high and busy is low. Each event gives exactly one result beat on the
//   out_ ports, marked by out_valid for a single cycle.
//   For peer request, want-enter, token arrival and an ignored exit, the
//   event passes the EXEC state and the registered beat follows. An exit
//   from the granted phase runs EXEC, then the node scan in tmn_core, one
//   node per cycle through the shared sequence unit over n = min(node_count,
//   MAX_NODES) nodes, then POP, before the beat. busy is low again in the
//   cycle the beat is shown, so a new event can be taken then.
//   The receiver cannot stall: each beat is taken at the edge ending it.
//   Configuration goes through cfg_we/cfg_index/cfg_wdata; the user must do
//   it only while idle, the block does not enforce that. Writing
//   start_with_token also loads token ownership.
//   Reset (rst_n low at a clock edge): tables and queue length clear, phase
//   released, token not held, node_id 0, node_count 8.
module token_mutex_node import tmn_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int SEQ_BITS  = SEQ_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [LEN_BITS-1:0]        cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic [NODE_BITS-1:0]       in_source_node,
  input  logic [BYTE_BITS-1:0]       in_request_seq,
  input  logic [SLOTS*BYTE_BITS-1:0] in_token_served_in,
  input  logic [SLOTS*NODE_BITS-1:0] in_token_queue_in,
  input  logic [LEN_BITS-1:0]        in_token_queue_len_in,
  output logic                       out_valid,
  output logic [1:0]                 out_message_kind,
  output logic [NODE_BITS-1:0]       out_dest_node,
  output logic [BYTE_BITS-1:0]       out_own_seq,
  output logic [SLOTS*BYTE_BITS-1:0] out_token_served_out,
  output logic [SLOTS*NODE_BITS-1:0] out_token_queue_out,
  output logic [LEN_BITS-1:0]        out_token_queue_len_out,
  output logic [1:0]                 out_node_phase
);

  localparam logic [LEN_BITS-1:0] MaxN = LEN_BITS'(MAX_NODES);

  logic [NODE_BITS-1:0] node_id_r, node_id_nxt;
  logic [LEN_BITS-1:0]  node_count_r, node_count_nxt;
  cfg_view_t            cfg;
  res_t                 res;

  always_comb begin
    node_id_nxt    = node_id_r;
    node_count_nxt = node_count_r;
    if (cfg_we && cfg_index == CFG_NODE_ID)    node_id_nxt    = cfg_wdata[NODE_BITS-1:0];
    if (cfg_we && cfg_index == CFG_NODE_COUNT) node_count_nxt = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      node_count_r <= LEN_BITS'(SLOTS);
    end else begin
      node_id_r    <= node_id_nxt;
      node_count_r <= node_count_nxt;
    end
  end

  assign cfg.me        = node_id_r;
  assign cfg.n         = (node_count_r < MaxN) ? node_count_r : MaxN;
  assign cfg.hold_load = cfg_we && (cfg_index == CFG_START_TOK);
  assign cfg.hold_val  = cfg_wdata[0];

  tmn_core #(.SEQ_BITS(SEQ_BITS)) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_source_node     (in_source_node),
    .in_request_seq     (in_request_seq),
    .in_token_served    (in_token_served_in),
    .in_token_queue     (in_token_queue_in),
    .in_token_queue_len (in_token_queue_len_in),
    .done               (out_valid),
    .res                (res)
  );

  assign out_message_kind        = res.kind;
  assign out_dest_node           = res.dest;
  assign out_own_seq             = res.own_seq;
  assign out_token_served_out    = res.served;
  assign out_token_queue_out     = res.queue;
  assign out_token_queue_len_out = res.qlen;
  assign out_node_phase          = res.phase;

endmodule

FILE: tb/tb_token_mutex_node.sv
// Self-checking testbench for token_mutex_node: directed and random events,
// scored beat by beat against a predictor of the node kept in a scoreboard class.
// Depends on tmn_pkg and the token_mutex_node RTL.
`timescale 1ns / 1ps

module tb_token_mutex_node;
  import tmn_pkg::*;

  class reply_scoreboard;
    logic [7:0] req_num [SLOTS];
    logic [7:0] srv_num [SLOTS];
    logic [2:0] wq [SLOTS];
    int unsigned wq_len;
    phase_t phase;
    bit holding;
    logic [2:0] me;
    logic [3:0] node_cnt;
    res_t reply_queue [$];
    int errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        req_num[i] = '0;
        srv_num[i] = '0;
        wq[i] = '0;
      end
      wq_len = 0;
      phase = PH_RELEASED;
      holding = 1'b0;
      me = '0;
      node_cnt = 4'd8;
      errors = 0;
    endfunction

    function int unsigned nodes_used();
      return (node_cnt < SLOTS) ? node_cnt : SLOTS;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        CFG_NODE_ID: me = val[2:0];
        CFG_NODE_COUNT: node_cnt = val;
        CFG_START_TOK: holding = val[0];
        default: ;
      endcase
    endfunction

    function bit queued(int unsigned node);
      for (int k = 0; k < wq_len && k < SLOTS; k++)
        if (wq[k] == node) return 1'b1;
      return 1'b0;
    endfunction

    function res_t pack_token(logic [2:0] dest);
      res_t r;
      r = '0;
      r.kind = MSG_TOKEN;
      r.dest = dest;
      for (int i = 0; i < SLOTS; i++) begin
        r.served[8*i +: 8] = srv_num[i];
        r.queue[3*i +: 3] = wq[i];
      end
      r.qlen = wq_len[3:0];
      return r;
    endfunction

    function res_t predict_reply(action_t act, logic [2:0] src, logic [7:0] seq,
                                 logic [63:0] srv_in, logic [23:0] q_in,
                                 logic [3:0] len_in);
      res_t r;
      int unsigned n;
      logic [2:0] head;
      r = '0;
      r.kind = MSG_NONE;
      n = nodes_used();
      case (act)
        ACT_PEER: begin
          if (src < n && src != me) begin
            if (seq > req_num[src]) req_num[src] = seq;
            if (phase == PH_RELEASED && holding &&
                int'(req_num[src]) == int'(srv_num[src]) + 1) begin
              r = pack_token(src);
              holding = 1'b0;
            end
          end
        end
        ACT_WANT: begin
          if (phase == PH_RELEASED) begin
            if (holding) begin
              phase = PH_GRANTED;
              r.kind = MSG_ENTER;
            end else begin
              if (req_num[me] != 8'hFF) req_num[me] = req_num[me] + 8'd1;
              phase = PH_REQUESTED;
              r.kind = MSG_BCAST;
              r.own_seq = req_num[me];
            end
          end
        end
        ACT_TOKEN: begin
          if (phase == PH_REQUESTED && !holding) begin
            for (int i = 0; i < SLOTS; i++) begin
              srv_num[i] = srv_in[8*i +: 8];
              wq[i] = q_in[3*i +: 3];
            end
            wq_len = (len_in > SLOTS) ? SLOTS : len_in;
            holding = 1'b1;
            phase = PH_GRANTED;
            r.kind = MSG_ENTER;
          end
        end
        default: begin
          if (phase == PH_GRANTED) begin
            srv_num[me] = req_num[me];
            for (int i = 0; i < n; i++) begin
              if (i != me && int'(req_num[i]) == int'(srv_num[i]) + 1 &&
                  !queued(i) && wq_len < SLOTS) begin
                wq[wq_len] = i[2:0];
                wq_len++;
              end
            end
            if (wq_len > 0) begin
              head = wq[0];
              for (int k = 1; k < SLOTS; k++) wq[k-1] = wq[k];
              wq[SLOTS-1] = '0;
              wq_len--;
              r = pack_token(head);
              holding = 1'b0;
            end
            phase = PH_RELEASED;
          end
        end
      endcase
      r.phase = phase;
      return r;
    endfunction

    function void note_event(action_t act, logic [2:0] src, logic [7:0] seq,
                             logic [63:0] srv_in, logic [23:0] q_in, logic [3:0] len_in);
      reply_queue.push_back(predict_reply(act, src, seq, srv_in, q_in, len_in));
    endfunction

    function void check_reply(res_t got);
      res_t want;
      bit bad;
      if (reply_queue.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: kind=%0d dest=%0d phase=%0d", got.kind, got.dest,
                   got.phase);
        return;
      end
      want = reply_queue.pop_front();
      bad = (got.kind !== want.kind) || (got.dest !== want.dest) ||
            (got.own_seq !== want.own_seq) || (got.served !== want.served) ||
            (got.queue !== want.queue) || (got.qlen !== want.qlen) ||
            (got.phase !== want.phase);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: kind=%0d dest=%0d seq=%0d served=%h queue=%h len=%0d ph=%0d",
                   want.kind, want.dest, want.own_seq, want.served, want.queue, want.qlen,
                   want.phase);
          $display("         got: kind=%0d dest=%0d seq=%0d served=%h queue=%h len=%0d ph=%0d",
                   got.kind, got.dest, got.own_seq, got.served, got.queue, got.qlen,
                   got.phase);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [NODE_BITS-1:0] in_source_node = '0;
  logic [BYTE_BITS-1:0] in_request_seq = '0;
  logic [SLOTS*BYTE_BITS-1:0] in_token_served_in = '0;
  logic [SLOTS*NODE_BITS-1:0] in_token_queue_in = '0;
  logic [LEN_BITS-1:0] in_token_queue_len_in = '0;
  logic out_valid;
  logic [1:0] out_message_kind;
  logic [NODE_BITS-1:0] out_dest_node;
  logic [BYTE_BITS-1:0] out_own_seq;
  logic [SLOTS*BYTE_BITS-1:0] out_token_served_out;
  logic [SLOTS*NODE_BITS-1:0] out_token_queue_out;
  logic [LEN_BITS-1:0] out_token_queue_len_out;
  logic [1:0] out_node_phase;

  reply_scoreboard sb = new();
  int unsigned idle_pct = 0;
  res_t seen_beat;

  always #6 clk = ~clk;

  token_mutex_node u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_source_node(in_source_node),
    .in_request_seq(in_request_seq),
    .in_token_served_in(in_token_served_in),
    .in_token_queue_in(in_token_queue_in),
    .in_token_queue_len_in(in_token_queue_len_in),
    .out_valid(out_valid),
    .out_message_kind(out_message_kind),
    .out_dest_node(out_dest_node),
    .out_own_seq(out_own_seq),
    .out_token_served_out(out_token_served_out),
    .out_token_queue_out(out_token_queue_out),
    .out_token_queue_len_out(out_token_queue_len_out),
    .out_node_phase(out_node_phase)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_beat.kind = kind_t'(out_message_kind);
      seen_beat.dest = out_dest_node;
      seen_beat.own_seq = out_own_seq;
      seen_beat.served = out_token_served_out;
      seen_beat.queue = out_token_queue_out;
      seen_beat.qlen = out_token_queue_len_out;
      seen_beat.phase = phase_t'(out_node_phase);
      sb.check_reply(seen_beat);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [2:0] id, logic [3:0] cnt, logic swt);
    write_reg(CFG_NODE_ID, {1'b0, id});
    write_reg(CFG_NODE_COUNT, cnt);
    write_reg(CFG_START_TOK, {3'b000, swt});
    cfg_we <= 1'b0;
  endtask

  task automatic send_event(action_t act, logic [2:0] src, logic [7:0] seq,
                            logic [63:0] srv, logic [23:0] q, logic [3:0] len);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_source_node <= src;
    in_request_seq <= seq;
    in_token_served_in <= srv;
    in_token_queue_in <= q;
    in_token_queue_len_in <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_event(act, src, seq, srv, q, len);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.reply_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [63:0] served_as_requested();
    logic [63:0] s;
    for (int i = 0; i < SLOTS; i++) s[8*i +: 8] = sb.req_num[i];
    return s;
  endfunction

  task automatic random_event();
    action_t act;
    logic [2:0] src;
    logic [7:0] seq;
    logic [63:0] srv;
    logic [23:0] q;
    logic [3:0] len;
    int unsigned n;
    int unsigned pick;
    n = sb.nodes_used();
    srv = {$urandom, $urandom};
    q = 24'($urandom);
    len = 4'($urandom_range(0, 15));
    src = 3'($urandom);
    seq = 8'($urandom);
    if ($urandom_range(99) < 15) begin
      act = action_t'($urandom_range(0, 3));
    end else begin
      case (sb.phase)
        PH_RELEASED: act = ($urandom_range(99) < 40) ? ACT_WANT : ACT_PEER;
        PH_REQUESTED: act = ($urandom_range(99) < 45) ? ACT_TOKEN : ACT_PEER;
        default: act = ($urandom_range(99) < 45) ? ACT_EXIT : ACT_PEER;
      endcase
      if (act == ACT_PEER) begin
        src = 3'($urandom_range(0, n - 1));
        if (src == sb.me) src = 3'((src + 1) % n);
        pick = $urandom_range(99);
        if (pick < 50) seq = sb.req_num[src] + 8'd1;
        else if (pick < 75) seq = sb.srv_num[src] + 8'd1;
        else if (pick < 85) seq = sb.req_num[src];
      end else if (act == ACT_TOKEN) begin
        for (int i = 0; i < SLOTS; i++) begin
          pick = $urandom_range(0, 3);
          if (pick < 2) srv[8*i +: 8] = sb.req_num[i] - 8'd1;
          else if (pick == 2) srv[8*i +: 8] = sb.req_num[i];
        end
        if ($urandom_range(99) < 70) len = 4'($urandom_range(0, 3));
      end
    end
    send_event(act, src, seq, srv, q, len);
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [2:0] id;
    logic [3:0] cnt;
    logic swt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(3'd3, 4'd8, 1'b0);

    idle_pct = 29;
    send_event(ACT_EXIT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_TOKEN, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd3, 8'd200, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd5, 8'hFF, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd1, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_WANT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_WANT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd2, 8'd1, 64'd0, 24'd0, 4'd0);
    send_event(ACT_TOKEN, 3'd7, 8'hFF, 64'hFFFF_FEFF_FF00_FFFF, 24'hFF_FFFF, 4'hF);
    send_event(ACT_EXIT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd4, 8'd3, 64'd0, 24'd0, 4'd0);
    send_event(ACT_WANT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_TOKEN, 3'd0, 8'd0, 64'h0000_FE00_0000_0000, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd2, 8'd1, 64'd0, 24'd0, 4'd0);
    send_event(ACT_EXIT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    drain();
    configure(3'd0, 4'd4, 1'b1);
    send_event(ACT_PEER, 3'd6, 8'd9, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd0, 8'd9, 64'd0, 24'd0, 4'd0);
    send_event(ACT_PEER, 3'd2, 8'd1, 64'd0, 24'd0, 4'd0);
    send_event(ACT_WANT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_TOKEN, 3'd0, 8'd0, served_as_requested(), 24'($urandom), 4'd0);
    send_event(ACT_EXIT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_WANT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    send_event(ACT_EXIT, 3'd0, 8'd0, 64'd0, 24'd0, 4'd0);
    drain();

    for (int chunk = 0; chunk < 12; chunk++) begin
      idle_pct = (chunk < 4) ? 29 : (chunk < 8) ? 72 : 0;
      id = 3'($urandom);
      cnt = 4'($urandom_range(2, 8));
      swt = 1'($urandom);
      if (chunk == 0) begin
        id = 3'd0;
        cnt = 4'd2;
        swt = 1'b1;
      end else if (chunk == 1) begin
        id = 3'd7;
        cnt = 4'd8;
        swt = 1'b0;
      end else if (chunk == 2) begin
        cnt = 4'd15;
      end
      configure(id, cnt, swt);
      repeat (62) random_event();
      drain();
    end

    repeat (16) @(posedge clk);
    sb.errors += sb.reply_queue.size();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
